/* src/fai_pkg.sv */
// ----------------------------------------------------------------------------
// fai_pkg
// Shared widths and pipeline payload types of the fragment attribute
// interpolator.
// ----------------------------------------------------------------------------
package fai_pkg;

	localparam int FLD_W = 32;
	localparam int PROD_W = 64;
	localparam int MAG_W = 96;
	localparam int NUM_W = 98;
	localparam int DEN_W = 66;
	localparam int QUO_W = 32;
	localparam int NVERT = 3;

	localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic                    valid;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} sum_t;

	typedef struct packed {
		logic              valid;
		logic              deg;
		logic              ovf;
		logic              neg;
		logic [DEN_W-1:0]  den;
		logic [NUM_W-1:0]  rem;
		logic [QUO_W-1:0]  quo;
	} div_t;

endpackage

/* src/fragment_attribute_interpolator.sv */
// ----------------------------------------------------------------------------
// fragment_attribute_interpolator
// Perspective-correct barycentric interpolation of one attribute channel.
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle that start is high; busy is always
// low. Each result appears with done high for one cycle and cannot be held
// off. The path runs through four multiply/sum stages, two sign and range
// stages, a 32-stage one-bit-per-stage divider and an output register.
module fragment_attribute_interpolator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic signed [fai_pkg::FLD_W-1:0]  weight_a,
	input  logic signed [fai_pkg::FLD_W-1:0]  weight_b,
	input  logic signed [fai_pkg::FLD_W-1:0]  weight_c,
	input  logic [fai_pkg::FLD_W-1:0]         persp_a,
	input  logic [fai_pkg::FLD_W-1:0]         persp_b,
	input  logic [fai_pkg::FLD_W-1:0]         persp_c,
	input  logic signed [fai_pkg::FLD_W-1:0]  attr_a,
	input  logic signed [fai_pkg::FLD_W-1:0]  attr_b,
	input  logic signed [fai_pkg::FLD_W-1:0]  attr_c,
	output logic                              done,
	output logic signed [fai_pkg::FLD_W-1:0]  interp_value,
	output logic                              degenerate
);

	fai_pkg::sum_t sum;
	fai_pkg::div_t chain [fai_pkg::QUO_W+1];

	logic                      valid_s5, valid_s6, done_q;
	logic [fai_pkg::NUM_W-1:0] absn_s5;
	logic [fai_pkg::DEN_W-1:0] absd_s5;
	logic                      deg_s5, neg_s5;
	logic [fai_pkg::NUM_W-1:0] absn_s6;
	logic [fai_pkg::DEN_W-1:0] absd_s6;
	logic                      deg_s6, neg_s6, ovf_s6;
	logic [fai_pkg::FLD_W-1:0] value_q;
	logic                      deg_q;

	assign busy = 1'b0;

	fai_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.kind     (kind),
		.weight_a (weight_a),
		.weight_b (weight_b),
		.weight_c (weight_c),
		.persp_a  (persp_a),
		.persp_b  (persp_b),
		.persp_c  (persp_c),
		.attr_a   (attr_a),
		.attr_b   (attr_b),
		.attr_c   (attr_c),
		.sum      (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s5 <= sum.valid;
			valid_s6 <= valid_s5;
			done_q   <= chain[fai_pkg::QUO_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		absn_s5 <= sum.num[fai_pkg::NUM_W-1] ? (~sum.num + 1'b1) : sum.num;
		absd_s5 <= sum.den[fai_pkg::DEN_W-1] ? (~sum.den + 1'b1) : sum.den;
		deg_s5  <= sum.den == '0;
		neg_s5  <= sum.num[fai_pkg::NUM_W-1] ^ sum.den[fai_pkg::DEN_W-1];

		absn_s6 <= absn_s5;
		absd_s6 <= absd_s5;
		deg_s6  <= deg_s5;
		neg_s6  <= neg_s5;
		ovf_s6  <= absn_s5 >= {absd_s5, 32'b0};
	end

	assign chain[0].valid = valid_s6;
	assign chain[0].deg   = deg_s6;
	assign chain[0].ovf   = ovf_s6;
	assign chain[0].neg   = neg_s6;
	assign chain[0].den   = absd_s6;
	assign chain[0].rem   = ovf_s6 ? '0 : absn_s6;
	assign chain[0].quo   = '0;

	for (genvar k = 0; k < fai_pkg::QUO_W; k++) begin : g_div
		fai_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[k]),
			.dout   (chain[k+1])
		);
	end

	always_ff @(posedge clk) begin
		fai_pkg::div_t d;
		d = chain[fai_pkg::QUO_W];
		deg_q <= d.deg;
		priority if (d.deg) begin
			value_q <= '0;
		end else if (d.ovf || (d.neg ? d.quo > fai_pkg::SAT_NEG : d.quo > fai_pkg::SAT_POS)) begin
			value_q <= d.neg ? fai_pkg::SAT_NEG : fai_pkg::SAT_POS;
		end else begin
			value_q <= d.neg ? (~d.quo + 1'b1) : d.quo;
		end
	end

	assign done         = done_q;
	assign interp_value = value_q;
	assign degenerate   = deg_q;

endmodule

/* src/fai_mul.sv */
// ----------------------------------------------------------------------------
// fai_mul
// Four-stage product and sum front end: builds the exact signed numerator
// sum(w*q*a) and divisor sum(w*q), with q forced to one in linear mode.
// ----------------------------------------------------------------------------
module fai_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              kind,
	input  logic signed [fai_pkg::FLD_W-1:0]  weight_a,
	input  logic signed [fai_pkg::FLD_W-1:0]  weight_b,
	input  logic signed [fai_pkg::FLD_W-1:0]  weight_c,
	input  logic [fai_pkg::FLD_W-1:0]         persp_a,
	input  logic [fai_pkg::FLD_W-1:0]         persp_b,
	input  logic [fai_pkg::FLD_W-1:0]         persp_c,
	input  logic signed [fai_pkg::FLD_W-1:0]  attr_a,
	input  logic signed [fai_pkg::FLD_W-1:0]  attr_b,
	input  logic signed [fai_pkg::FLD_W-1:0]  attr_c,
	output fai_pkg::sum_t                     sum
);

	logic [fai_pkg::FLD_W-1:0] w_in [fai_pkg::NVERT];
	logic [fai_pkg::FLD_W-1:0] q_in [fai_pkg::NVERT];
	logic [fai_pkg::FLD_W-1:0] a_in [fai_pkg::NVERT];

	logic                       valid_s1, valid_s2, valid_s3, valid_s4;
	logic [fai_pkg::PROD_W-1:0] wq_s1  [fai_pkg::NVERT];
	logic [fai_pkg::FLD_W-1:0]  ma_s1  [fai_pkg::NVERT];
	logic                       nw_s1  [fai_pkg::NVERT];
	logic                       sg_s1  [fai_pkg::NVERT];
	logic [fai_pkg::PROD_W-1:0] lo_s2  [fai_pkg::NVERT];
	logic [fai_pkg::PROD_W-1:0] hi_s2  [fai_pkg::NVERT];
	logic [fai_pkg::DEN_W-1:0]  dt_s2  [fai_pkg::NVERT];
	logic                       sg_s2  [fai_pkg::NVERT];
	logic [fai_pkg::NUM_W-1:0]  tm_s3  [fai_pkg::NVERT];
	logic [fai_pkg::DEN_W-1:0]  den_s3;
	logic [fai_pkg::NUM_W-1:0]  num_s4;
	logic [fai_pkg::DEN_W-1:0]  den_s4;

	assign w_in[0] = weight_a;
	assign w_in[1] = weight_b;
	assign w_in[2] = weight_c;
	assign q_in[0] = kind ? persp_a : fai_pkg::FLD_W'(1);
	assign q_in[1] = kind ? persp_b : fai_pkg::FLD_W'(1);
	assign q_in[2] = kind ? persp_c : fai_pkg::FLD_W'(1);
	assign a_in[0] = attr_a;
	assign a_in[1] = attr_b;
	assign a_in[2] = attr_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// magnitude products; sign applied after the last multiply
	always_ff @(posedge clk) begin
		for (int i = 0; i < fai_pkg::NVERT; i++) begin
			logic [fai_pkg::FLD_W-1:0] mw;
			logic [fai_pkg::FLD_W-1:0] ma;
			logic [fai_pkg::MAG_W-1:0] mag;
			mw = w_in[i][fai_pkg::FLD_W-1] ? (~w_in[i] + 1'b1) : w_in[i];
			ma = a_in[i][fai_pkg::FLD_W-1] ? (~a_in[i] + 1'b1) : a_in[i];
			wq_s1[i] <= fai_pkg::PROD_W'(mw) * fai_pkg::PROD_W'(q_in[i]);
			ma_s1[i] <= ma;
			nw_s1[i] <= w_in[i][fai_pkg::FLD_W-1];
			sg_s1[i] <= w_in[i][fai_pkg::FLD_W-1] ^ a_in[i][fai_pkg::FLD_W-1];

			lo_s2[i] <= fai_pkg::PROD_W'(wq_s1[i][31:0]) * fai_pkg::PROD_W'(ma_s1[i]);
			hi_s2[i] <= fai_pkg::PROD_W'(wq_s1[i][63:32]) * fai_pkg::PROD_W'(ma_s1[i]);
			dt_s2[i] <= nw_s1[i] ? (~fai_pkg::DEN_W'(wq_s1[i]) + 1'b1)
				: fai_pkg::DEN_W'(wq_s1[i]);
			sg_s2[i] <= sg_s1[i];

			mag = fai_pkg::MAG_W'(lo_s2[i]) + {hi_s2[i], 32'b0};
			tm_s3[i] <= sg_s2[i] ? (~fai_pkg::NUM_W'(mag) + 1'b1) : fai_pkg::NUM_W'(mag);
		end
		den_s3 <= dt_s2[0] + dt_s2[1] + dt_s2[2];
		num_s4 <= tm_s3[0] + tm_s3[1] + tm_s3[2];
		den_s4 <= den_s3;
	end

	assign sum.valid = valid_s4;
	assign sum.num   = num_s4;
	assign sum.den   = den_s4;

endmodule

/* src/fai_div_stage.sv */
// ----------------------------------------------------------------------------
// fai_div_stage
// One restoring division step: produces one quotient bit and shifts the
// partial remainder left for the next stage.
// ----------------------------------------------------------------------------
module fai_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  fai_pkg::div_t  din,
	output fai_pkg::div_t  dout
);

	logic [fai_pkg::DEN_W:0]   top;
	logic [fai_pkg::DEN_W:0]   diff;
	logic                      ge;
	logic [fai_pkg::NUM_W-1:0] rem_nx;

	// remainder stays below den<<32, so bits 97:31 hold the trial window
	assign top    = din.rem[fai_pkg::NUM_W-1:31];
	assign diff   = top - {1'b0, din.den};
	assign ge     = top >= {1'b0, din.den};
	assign rem_nx = ge ? {diff, din.rem[30:0]} : din.rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.deg   <= din.deg;
			dout.ovf   <= din.ovf;
			dout.neg   <= din.neg;
			dout.den   <= din.den;
			dout.rem   <= {rem_nx[fai_pkg::NUM_W-2:0], 1'b0};
			dout.quo   <= {din.quo[fai_pkg::QUO_W-2:0], ge};
		end
	end

endmodule
